### hdl/fxmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fxmd_pkg
// Shared types and constants for the signed 16.16 multiply/divide unit.
// ----------------------------------------------------------------------------
package fxmd_pkg;

    // Data width of operands and result
    localparam int DATA_W = 32;

    // Default number of fraction bits
    localparam int FRAC_BITS_DEF = 16;

    // Operation codes carried on tuser
    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    // Saturation values
    localparam logic [DATA_W-1:0] RES_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] RES_MIN = 32'h8000_0000;

    // Control and product carried alongside the divider chain
    typedef struct packed {
        logic              valid;
        logic              is_div;
        logic              neg;
        logic              sat;
        logic [DATA_W-1:0] prod;
    } fxmd_tag_t;

endpackage : fxmd_pkg
`default_nettype wire

### hdl/fixed_16_16_mul_div_unit.sv
// Stages: one entry stage, 2*FRAC_BITS-2 division cells and one output
//   register, passed in that order between request and result.
// Throughput: one request per cycle while not stalled; the division chain
//   takes one quotient bit per cell and multiplies ride along the same chain.
// Backpressure stalls the whole chain while the output result waits.
// Reset: aresetn synchronous active low, clears all valid bits; no sweep.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_16_16_mul_div_unit
// Signed fixed-point multiply/divide with saturating divide, built as a
// chain of restoring-division cells.
// ----------------------------------------------------------------------------
module fixed_16_16_mul_div_unit #(
    parameter int FRAC_BITS = fxmd_pkg::FRAC_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] operand_a, [63:32] operand_b
    input  wire logic        s_tuser,   // [0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [31:0] result
);
    import fxmd_pkg::*;

    localparam int QB = 2 * FRAC_BITS - 2;

    logic      en;
    fxmd_tag_t tag_w [0:QB];
    logic [DATA_W-1:0] rem_w [0:QB];
    logic [QB-1:0]     qd_w  [0:QB];
    logic [DATA_W-1:0] mb_w  [0:QB];

    // Advance the chain whenever the output slot is free or drained
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    fxmd_entry #(
        .FRAC_BITS (FRAC_BITS),
        .QB        (QB)
    ) u_entry (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .req_type  (s_tuser),
        .operand_a (s_tdata[31:0]),
        .operand_b (s_tdata[63:32]),
        .tag_reg   (tag_w[0]),
        .rem_reg   (rem_w[0]),
        .qd_reg    (qd_w[0]),
        .mb_reg    (mb_w[0])
    );

    // Division cells, one quotient bit each
    for (genvar i = 0; i < QB; i++) begin : g_cell
        fxmd_div_cell #(
            .QB (QB)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .tag_in  (tag_w[i]),
            .rem_in  (rem_w[i]),
            .qd_in   (qd_w[i]),
            .mb_in   (mb_w[i]),
            .tag_reg (tag_w[i+1]),
            .rem_reg (rem_w[i+1]),
            .qd_reg  (qd_w[i+1]),
            .mb_reg  (mb_w[i+1])
        );
    end

    fxmd_exit #(
        .QB (QB)
    ) u_exit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .tag_in   (tag_w[QB]),
        .qd_in    (qd_w[QB]),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule : fixed_16_16_mul_div_unit
`default_nettype wire

### hdl/fxmd_entry.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fxmd_entry
// Front stage: forms operand magnitudes, the overflow guard, the initial
// partial remainder and the shifted product, and registers them.
// ----------------------------------------------------------------------------
module fxmd_entry #(
    parameter int FRAC_BITS = 16,
    parameter int QB        = 2 * FRAC_BITS - 2
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic                  req_type,
    input  wire logic [31:0]           operand_a,
    input  wire logic [31:0]           operand_b,
    output fxmd_pkg::fxmd_tag_t        tag_reg,
    output logic [31:0]                rem_reg,
    output logic [QB-1:0]              qd_reg,
    output logic [31:0]                mb_reg
);
    import fxmd_pkg::*;

    logic [DATA_W-1:0]           ma;
    logic [DATA_W-1:0]           mb;
    logic [DATA_W+FRAC_BITS-1:0] dvd;
    logic [DATA_W-1:0]           rem_next;
    logic signed [2*DATA_W-1:0]  prod_full;
    fxmd_tag_t                   tag_next;

    // Take magnitudes as unsigned values
    always_comb begin
        ma  = operand_a[DATA_W-1] ? (32'd0 - operand_a) : operand_a;
        mb  = operand_b[DATA_W-1] ? (32'd0 - operand_b) : operand_b;
        dvd = {ma, {FRAC_BITS{1'b0}}};
        // High part of the dividend seeds the remainder
        rem_next = DATA_W'(ma >> (FRAC_BITS - 2));
    end

    // Full signed product
    assign prod_full = $signed(operand_a) * $signed(operand_b);

    // Build the tag
    always_comb begin
        tag_next.valid  = in_valid;
        tag_next.is_div = (req_type == OP_DIV);
        tag_next.neg    = operand_a[DATA_W-1] ^ operand_b[DATA_W-1];
        tag_next.sat    = (rem_next >= mb);
        tag_next.prod   = prod_full[FRAC_BITS+DATA_W-1:FRAC_BITS];
    end

    // Stage register; clear valid on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg.valid <= 1'b0;
        end else if (en) begin
            tag_reg <= tag_next;
            rem_reg <= rem_next;
            qd_reg  <= dvd[QB-1:0];
            mb_reg  <= mb;
        end
    end

endmodule : fxmd_entry
`default_nettype wire

### hdl/fxmd_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fxmd_div_cell
// One restoring-division cell: shifts in one dividend bit, compares against
// the divisor, subtracts on success and shifts the quotient bit in.
// ----------------------------------------------------------------------------
module fxmd_div_cell #(
    parameter int QB = 30
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire fxmd_pkg::fxmd_tag_t   tag_in,
    input  wire logic [31:0]           rem_in,
    input  wire logic [QB-1:0]         qd_in,
    input  wire logic [31:0]           mb_in,
    output fxmd_pkg::fxmd_tag_t        tag_reg,
    output logic [31:0]                rem_reg,
    output logic [QB-1:0]              qd_reg,
    output logic [31:0]                mb_reg
);
    import fxmd_pkg::*;

    logic [DATA_W:0]   rem_sh;
    logic [DATA_W+1:0] diff;
    logic              ge;
    logic [DATA_W-1:0] rem_next;
    logic [QB-1:0]     qd_next;

    // Trial subtract
    always_comb begin
        rem_sh   = {rem_in, qd_in[QB-1]};
        diff     = {1'b0, rem_sh} - {2'b00, mb_in};
        ge       = ~diff[DATA_W+1];
        rem_next = ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
        qd_next  = {qd_in[QB-2:0], ge};
    end

    // Advance the cell; clear valid on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg.valid <= 1'b0;
        end else if (en) begin
            tag_reg <= tag_in;
            rem_reg <= rem_next;
            qd_reg  <= qd_next;
            mb_reg  <= mb_in;
        end
    end

    // Partial remainder stays below the divisor for a live divide
    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (tag_reg.valid && tag_reg.is_div && !tag_reg.sat) |-> (rem_reg < mb_reg))
        else $error("fxmd_div_cell: remainder not below divisor");

endmodule : fxmd_div_cell
`default_nettype wire

### hdl/fxmd_exit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fxmd_exit
// Output stage: applies sign and saturation to the quotient, selects the
// product for multiplies and holds the result for the master side.
// ----------------------------------------------------------------------------
module fxmd_exit #(
    parameter int QB = 30
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire fxmd_pkg::fxmd_tag_t   tag_in,
    input  wire logic [QB-1:0]         qd_in,
    output logic                       m_tvalid,
    output logic [31:0]                m_tdata
);
    import fxmd_pkg::*;

    logic [2*DATA_W-1:0] q_ext;
    logic [2*DATA_W-1:0] q_sgn;
    logic [DATA_W-1:0]   res_next;

    // Sign, saturate, select
    always_comb begin
        q_ext = (2*DATA_W)'(qd_in);
        q_sgn = tag_in.neg ? ((2*DATA_W)'(0) - q_ext) : q_ext;
        if (!tag_in.is_div) begin
            res_next = tag_in.prod;
        end else if (tag_in.sat) begin
            res_next = tag_in.neg ? RES_MIN : RES_MAX;
        end else begin
            res_next = q_sgn[DATA_W-1:0];
        end
    end

    // Output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (en) begin
            m_tvalid <= tag_in.valid;
        end
    end

    // Output data
    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata <= res_next;
        end
    end

    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && tag_in.valid && tag_in.is_div && tag_in.sat)
        |=> (m_tdata == RES_MAX || m_tdata == RES_MIN))
        else $error("fxmd_exit: saturated divide gave a non-limit value");

    a_valid_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        en |=> (m_tvalid == $past(tag_in.valid)))
        else $error("fxmd_exit: output valid does not follow the chain");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("fxmd_exit: output valid set after reset");

endmodule : fxmd_exit
`default_nettype wire

### tb/fxmd_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxmd_result_checker
// Passive checker for the signed fixed-point multiply/divide unit. It watches
// both stream channels, computes the product or quotient of every accepted
// request and compares each returned result with the oldest one still due.
// ----------------------------------------------------------------------------
module fxmd_result_checker #(
    parameter int FRAC_BITS = fxmd_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,      // [31:0] operand_a, [63:32] operand_b
    input  logic        s_tuser,      // [0] req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,      // [31:0] result
    output int          fail_count,
    output int          outstanding
);
    import fxmd_pkg::*;

    // One request in flight, kept with its operands for reporting
    typedef struct packed {
        logic              op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] result;
    } fx_due_t;

    fx_due_t results_due[$];

    // Product or saturating quotient of two signed fixed-point operands
    function automatic logic [DATA_W-1:0] fx_mul_div(input logic op,
                                                    input logic [DATA_W-1:0] a,
                                                    input logic [DATA_W-1:0] b);
        logic [63:0]       prod;
        logic [63:0]       quo;
        logic [DATA_W-1:0] mag_a;
        logic [DATA_W-1:0] mag_b;
        logic              neg;
        mag_a = a[DATA_W-1] ? (32'd0 - a) : a;
        mag_b = b[DATA_W-1] ? (32'd0 - b) : b;
        neg   = a[DATA_W-1] ^ b[DATA_W-1];
        if (op == OP_DIV) begin
            // Saturate when the quotient cannot fit; this also covers b == 0
            if ((mag_a >> (FRAC_BITS - 2)) >= mag_b)
                return neg ? RES_MIN : RES_MAX;
            quo = ({32'd0, mag_a} << FRAC_BITS) / {32'd0, mag_b};
            if (neg)
                quo = 64'd0 - quo;
            return quo[DATA_W-1:0];
        end
        // Full signed product, shifted down; overflow wraps
        prod = {{32{a[DATA_W-1]}}, a} * {{32{b[DATA_W-1]}}, b};
        prod = prod >> FRAC_BITS;
        return prod[DATA_W-1:0];
    endfunction

    // Retire results, then queue the prediction for a new request
    always @(posedge aclk) begin : track
        fx_due_t head;
        fx_due_t entry;
        if (!aresetn) begin
            results_due.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (results_due.size() == 0) begin
                    fail_count <= fail_count + 1;
                    $display("%0t: result with no request pending: expected none, actual %h",
                             $time, m_tdata);
                end else begin
                    head = results_due.pop_front();
                    if (m_tdata !== head.result) begin
                        fail_count <= fail_count + 1;
                        $display("%0t: %s a=%h b=%h: expected %h, actual %h", $time,
                                 (head.op == OP_DIV) ? "div" : "mul", head.a, head.b,
                                 head.result, m_tdata);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                entry.op     = s_tuser;
                entry.a      = s_tdata[31:0];
                entry.b      = s_tdata[63:32];
                entry.result = fx_mul_div(s_tuser, s_tdata[31:0], s_tdata[63:32]);
                results_due.push_back(entry);
            end
            outstanding <= results_due.size();
        end
    end

endmodule : fxmd_result_checker

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the fixed-point multiply/divide unit: directed corner requests
// followed by random multiplies and divides, with random idle bursts on both
// channels, one long result stall and one full drain. Checking is done by
// the result checker beside the unit.
// ----------------------------------------------------------------------------
module tb_top;
    import fxmd_pkg::*;

    localparam int N_RANDOM       = 1800;
    localparam int HOLD_AT        = 600;
    localparam int DRAIN_AT       = 1200;
    localparam int CALM_AT        = 1500;
    localparam int LONG_HOLD      = 240;
    localparam int SETTLE         = 4 * FRAC_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 4000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;     // [31:0] operand_a, [63:32] operand_b
    logic        s_tuser  = 1'b0;   // [0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [31:0] result

    int fail_count;
    int outstanding;
    int req_num      = 0;
    int quiet_cycles = 0;
    bit bursts_on    = 1'b1;
    bit hold_off_now = 1'b0;

    fixed_16_16_mul_div_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    fxmd_result_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // 250 MHz clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // Hold reset asserted after start, then release it
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Result side: mostly ready, random stall bursts, one long hold-off
    initial begin
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_off_now) begin
                hold_off_now = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (bursts_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog: no request or result moved in %0d cycles",
                     $time, WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Mix of full-range, small fixed-point, special and power-of-two values
    function automatic logic [31:0] rand_operand();
        logic [31:0] v;
        int          k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6: begin
                k = $urandom_range(1, 23);
                v = $urandom & ((32'd1 << k) - 32'd1);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            7, 8: begin
                case ($urandom_range(0, 5))
                    0:       v = 32'd0;
                    1:       v = 32'h0001_0000;
                    2:       v = 32'hFFFF_0000;
                    3:       v = RES_MAX;
                    4:       v = RES_MIN;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default: begin
                v = 32'd1 << $urandom_range(0, 31);
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    // Offer one request until taken, then apply drain, hold-off or idle gap
    task automatic issue_req(input logic op, input logic [31:0] a, input logic [31:0] b);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {b, a};
        do @(posedge aclk); while (!s_tready);
        req_num++;
        if (req_num == HOLD_AT)
            hold_off_now = 1'b1;
        if (req_num == DRAIN_AT) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (outstanding != 0);
        end else if (bursts_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        if (req_num >= CALM_AT)
            bursts_on = 1'b0;
    endtask

    initial begin
        logic        op;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] mag_a;
        wait (aresetn);
        @(posedge aclk);

        // Multiply corners: zero, extremes, unity, sub-LSB product, wrap
        issue_req(OP_MUL, 32'd0,         32'd0);
        issue_req(OP_MUL, RES_MAX,       RES_MAX);
        issue_req(OP_MUL, RES_MIN,       RES_MIN);
        issue_req(OP_MUL, RES_MIN,       RES_MAX);
        issue_req(OP_MUL, 32'h0001_0000, 32'h0001_0000);
        issue_req(OP_MUL, 32'hFFFF_0000, 32'h0001_8000);
        issue_req(OP_MUL, 32'd1,         32'd1);
        issue_req(OP_MUL, 32'hFFFF_FFFF, 32'd1);
        issue_req(OP_MUL, 32'h7FFF_0000, 32'h0002_0000);
        issue_req(OP_MUL, RES_MIN,       32'hFFFF_FFFF);

        // Divide corners: by zero of either sign, extremes, guard boundary
        issue_req(OP_DIV, 32'h0001_0000, 32'd0);
        issue_req(OP_DIV, 32'hFFFF_0000, 32'd0);
        issue_req(OP_DIV, 32'd0,         32'd0);
        issue_req(OP_DIV, RES_MIN,       RES_MIN);
        issue_req(OP_DIV, RES_MIN,       32'hFFFF_FFFF);
        issue_req(OP_DIV, RES_MAX,       RES_MIN);
        issue_req(OP_DIV, RES_MAX,       RES_MAX);
        issue_req(OP_DIV, 32'h0001_0000, 32'h0003_0000);
        issue_req(OP_DIV, 32'hFFF8_8000, 32'h0002_0000);
        issue_req(OP_DIV, 32'h0004_0000, 32'h0000_0010);
        issue_req(OP_DIV, 32'h0004_0000, 32'h0000_0011);
        issue_req(OP_DIV, 32'h0004_0000, 32'hFFFF_FFEF);

        // Random requests; a third of the divides land on the saturation edge
        repeat (N_RANDOM) begin
            op = 1'($urandom_range(0, 1));
            a  = rand_operand();
            b  = rand_operand();
            if (op == OP_DIV && $urandom_range(0, 2) == 0) begin
                mag_a = a[31] ? -a : a;
                b = (mag_a >> (FRAC_BITS_DEF - 2)) + 32'($urandom_range(0, 2)) - 32'd1;
                if ($urandom_range(0, 1))
                    b = -b;
            end
            issue_req(op, a, b);
        end
        s_tvalid <= 1'b0;

        // Wait for the last results, then let the chain settle
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE) @(posedge aclk);

        if (fail_count == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule : tb_top

### sim.f
hdl/fxmd_pkg.sv
hdl/fxmd_entry.sv
hdl/fxmd_div_cell.sv
hdl/fxmd_exit.sv
hdl/fixed_16_16_mul_div_unit.sv
tb/fxmd_result_checker.sv
tb/tb_top.sv
